### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent property wrappers
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### rtl/mlp2_pkg.sv
// ---------------------------------------------------------------------------
// mlp2_pkg
// shared types, constants and the sigmoid table of the perceptron core
// ---------------------------------------------------------------------------
package mlp2_pkg;

  localparam int AW    = 9;
  localparam int WW    = 16;
  localparam int FW    = 8;
  localparam int OPW   = 10;
  localparam int PW    = OPW + WW;
  localparam int ACCW  = 32;
  localparam int OUTW  = 24;
  localparam int OIW   = 4;
  localparam int DEPTH = 512;

  localparam logic LAYER_HID = 1'b0;
  localparam logic LAYER_OUT = 1'b1;

  typedef struct packed {
    logic                  valid;
    logic                  layer;
    logic                  first;
    logic                  lastk;
    logic signed [OPW-1:0] opd;
    logic [AW-1:0]         addr;
  } issue_t;

  typedef struct packed {
    logic                   valid;
    logic                   layer;
    logic signed [ACCW-1:0] value;
  } result_t;

  function automatic logic [7:0] sig_lut(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd8, 6'd9, 6'd10, 6'd11: v = 8'd1;
      6'd12, 6'd13: v = 8'd2;
      6'd14: v = 8'd3;   6'd15: v = 8'd4;   6'd16: v = 8'd5;   6'd17: v = 8'd6;
      6'd18: v = 8'd8;   6'd19: v = 8'd10;  6'd20: v = 8'd12;  6'd21: v = 8'd15;
      6'd22: v = 8'd19;  6'd23: v = 8'd24;  6'd24: v = 8'd31;  6'd25: v = 8'd38;
      6'd26: v = 8'd47;  6'd27: v = 8'd57;  6'd28: v = 8'd69;  6'd29: v = 8'd82;
      6'd30: v = 8'd97;  6'd31: v = 8'd112; 6'd32: v = 8'd128; 6'd33: v = 8'd144;
      6'd34: v = 8'd159; 6'd35: v = 8'd174; 6'd36: v = 8'd187; 6'd37: v = 8'd199;
      6'd38: v = 8'd209; 6'd39: v = 8'd218; 6'd40: v = 8'd225; 6'd41: v = 8'd232;
      6'd42: v = 8'd237; 6'd43: v = 8'd241; 6'd44: v = 8'd244; 6'd45: v = 8'd246;
      6'd46: v = 8'd248; 6'd47: v = 8'd250; 6'd48: v = 8'd251; 6'd49: v = 8'd252;
      6'd50: v = 8'd253; 6'd51, 6'd52: v = 8'd254;
      default: v = (idx < 6'd8) ? 8'd0 : 8'd255;
    endcase
    return v;
  endfunction

endpackage

### rtl/mlp2_cell.sv
// ---------------------------------------------------------------------------
// mlp2_cell
// one storage cell of a rotating operand row
// ---------------------------------------------------------------------------
module mlp2_cell #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         ld,
  input  logic [W-1:0] ld_d,
  input  logic         sh,
  input  logic [W-1:0] sh_d,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      q_r <= ld_d;
    end else if (sh) begin
      q_r <= sh_d;
    end
  end

  assign q = q_r;

endmodule

### rtl/mlp2_mac.sv
// ---------------------------------------------------------------------------
// mlp2_mac
// weight store, multiplier and accumulator, three stages deep
// ---------------------------------------------------------------------------
module mlp2_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [mlp2_pkg::AW-1:0]   wr_addr,
  input  logic [mlp2_pkg::WW-1:0]   wr_data,
  input  mlp2_pkg::issue_t          iss,
  output logic                      busy,
  output mlp2_pkg::result_t         res
);

  logic [mlp2_pkg::WW-1:0] mem [mlp2_pkg::DEPTH];
  logic [mlp2_pkg::WW-1:0] rdata_r;
  mlp2_pkg::issue_t s1_r, s2_r;
  logic signed [mlp2_pkg::PW-1:0]   prod_r;
  logic signed [mlp2_pkg::ACCW-1:0] acc_r, acc_nxt;
  mlp2_pkg::result_t res_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[iss.addr];
  end

  always_comb begin
    acc_nxt = (s2_r.first ? '0 : acc_r) + mlp2_pkg::ACCW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      s1_r        <= iss;
      s2_r        <= s1_r;
      res_r.valid <= s2_r.valid && s2_r.lastk;
    end
    prod_r <= s1_r.opd * $signed(rdata_r);
    if (s2_r.valid) begin
      acc_r <= acc_nxt;
    end
    res_r.layer <= s2_r.layer;
    res_r.value <= acc_nxt;
  end

  assign busy = s1_r.valid || s2_r.valid || res_r.valid;
  assign res  = res_r;

endmodule

### rtl/mlp_two_layer_inference_core.sv
// ---------------------------------------------------------------------------
// mlp_two_layer_inference_core
// two-layer perceptron: sigmoid hidden layer, linear rounded output layer
// ---------------------------------------------------------------------------
// load items and non-final features: one cycle each
// final feature: starts both layers, computed on the single multiply-accumulate unit
//   and its one weight store read port
// no new item while computing
// rst_n synchronous active low clears control state; weight store holds no reset
module mlp_two_layer_inference_core #(
  parameter int IN_SIZE     = 16,
  parameter int HIDDEN_SIZE = 16,
  parameter int OUT_SIZE    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // weight_index[8:0], weight_value[24:9], feature_value[32:25]
  input  logic        in_tuser,   // req_type
  input  logic        in_tlast,   // last_feature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // output_index[3:0], output_value[27:4]
  output logic        out_tlast   // last_output
);

  localparam int MX   = (IN_SIZE > HIDDEN_SIZE) ? IN_SIZE : HIDDEN_SIZE;
  localparam int KW   = $clog2(MX + 1);
  localparam int JW   = $clog2(((MX > OUT_SIZE) ? MX : OUT_SIZE) + 1);
  localparam int CW   = $clog2(IN_SIZE + 1);
  localparam int B1   = IN_SIZE * HIDDEN_SIZE;
  localparam int W2B  = B1 + HIDDEN_SIZE;
  localparam int B2B  = W2B + HIDDEN_SIZE * OUT_SIZE;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_L1   = 2'd1;
  localparam logic [1:0] S_L2   = 2'd2;
  localparam logic [1:0] S_WAIT = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          acc_in, feat_wr, feat_rot, hid_rot, hid_new;
  logic [7:0]    sig_val;
  logic [7:0]    feat_q [IN_SIZE];
  logic [7:0]    hid_q  [HIDDEN_SIZE];
  mlp2_pkg::issue_t  iss;
  mlp2_pkg::result_t res;
  logic          mac_busy;

  logic                             ov_r;
  logic [mlp2_pkg::OIW-1:0]         oidx_r;
  logic [mlp2_pkg::OUTW-1:0]        oval_r;
  logic                             olast_r;
  logic signed [mlp2_pkg::ACCW:0]   t_sig;
  logic signed [mlp2_pkg::ACCW-1:0] y_rnd;

  assign in_tready = (state_r == S_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign feat_wr   = acc_in && in_tuser && (cnt_r < CW'(IN_SIZE));

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    cnt_nxt   = cnt_r;
    feat_rot  = 1'b0;
    hid_rot   = 1'b0;
    iss       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (feat_wr) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (acc_in && in_tuser && in_tlast) begin
          state_nxt = S_L1;
          k_nxt     = '0;
          j_nxt     = '0;
        end
      end
      S_L1: begin
        iss.valid = 1'b1;
        iss.layer = mlp2_pkg::LAYER_HID;
        iss.first = (k_r == '0);
        iss.lastk = (k_r == KW'(IN_SIZE));
        if (iss.lastk) begin
          iss.opd  = 10'sd1;
          iss.addr = mlp2_pkg::AW'(B1 + int'(j_r));
          k_nxt    = '0;
          j_nxt    = j_r + 1'b1;
          if (j_r == JW'(HIDDEN_SIZE - 1)) begin
            state_nxt = S_WAIT;
          end
        end else begin
          feat_rot = 1'b1;
          iss.opd  = (KW'(cnt_r) > k_r) ? {{2{feat_q[0][7]}}, feat_q[0]} : '0;
          iss.addr = mlp2_pkg::AW'(int'(k_r) * HIDDEN_SIZE + int'(j_r));
          k_nxt    = k_r + 1'b1;
        end
      end
      S_L2: begin
        if (k_r != '0 || !ov_r) begin
          iss.valid = 1'b1;
          iss.layer = mlp2_pkg::LAYER_OUT;
          iss.first = (k_r == '0);
          iss.lastk = (k_r == KW'(HIDDEN_SIZE));
          if (iss.lastk) begin
            iss.opd   = 10'sd256;
            iss.addr  = mlp2_pkg::AW'(B2B + int'(j_r));
            k_nxt     = '0;
            j_nxt     = j_r + 1'b1;
            state_nxt = S_WAIT;
          end else begin
            hid_rot  = 1'b1;
            iss.opd  = {2'b00, hid_q[0]};
            iss.addr = mlp2_pkg::AW'(W2B + int'(k_r) * OUT_SIZE + int'(j_r));
            k_nxt    = k_r + 1'b1;
          end
        end
      end
      S_WAIT: begin
        if (!mac_busy) begin
          if (j_r == JW'(OUT_SIZE) && cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else if (j_r == JW'(HIDDEN_SIZE) && cnt_r != '0) begin
            state_nxt = S_L2;
            j_nxt     = '0;
            cnt_nxt   = '0;
          end else begin
            state_nxt = S_L2;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // feature row
  for (genvar i = 0; i < IN_SIZE; i++) begin : g_feat
    mlp2_cell #(.W(8)) u_cell (
      .clk  (clk),
      .ld   (feat_wr && (cnt_r == CW'(i))),
      .ld_d (in_tdata[32:25]),
      .sh   (feat_rot),
      .sh_d (feat_q[(i + 1) % IN_SIZE]),
      .q    (feat_q[i])
    );
  end

  // hidden activation row
  assign t_sig   = (mlp2_pkg::ACCW + 1)'(res.value) + 33'sd2080;
  assign sig_val = mlp2_pkg::sig_lut((t_sig < 0) ? 6'd0 :
                                     (t_sig > 33'sd4095) ? 6'd63 : t_sig[11:6]);
  assign hid_new = res.valid && (res.layer == mlp2_pkg::LAYER_HID);

  for (genvar i = 0; i < HIDDEN_SIZE; i++) begin : g_hid
    mlp2_cell #(.W(8)) u_cell (
      .clk  (clk),
      .ld   (hid_new && (i == HIDDEN_SIZE - 1)),
      .ld_d (sig_val),
      .sh   (hid_new || hid_rot),
      .sh_d (hid_q[(i + 1) % HIDDEN_SIZE]),
      .q    (hid_q[i])
    );
  end

  mlp2_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (acc_in && !in_tuser),
    .wr_addr (in_tdata[8:0]),
    .wr_data (in_tdata[24:9]),
    .iss     (iss),
    .busy    (mac_busy),
    .res     (res)
  );

  // output register
  assign y_rnd = (res.value + 32'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (res.valid && res.layer == mlp2_pkg::LAYER_OUT) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
    if (res.valid && res.layer == mlp2_pkg::LAYER_OUT) begin
      oidx_r  <= mlp2_pkg::OIW'(j_r - 1'b1);
      oval_r  <= y_rnd[mlp2_pkg::OUTW-1:0];
      olast_r <= (j_r == JW'(OUT_SIZE));
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, oval_r, oidx_r};
  assign out_tlast  = olast_r;

endmodule

### rtl/mlp2_checker.sv
// ---------------------------------------------------------------------------
// mlp2_checker
// port-level checks of the perceptron core
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mlp2_checker #(
  parameter int OUT_SIZE = 4
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_IMPL(a_last_idx, clk, rst_n, out_tvalid && out_tlast, out_tdata[3:0] == 4'(OUT_SIZE - 1))
  `CHK_NEXT(a_busy_after_last, clk, rst_n, in_tvalid && in_tready && in_tuser && in_tlast, !in_tready)
  `CHK_IMPL(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[31:28] == 4'd0)

endmodule

bind mlp_two_layer_inference_core mlp2_checker #(.OUT_SIZE(OUT_SIZE)) u_mlp2_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
